>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mwo checker: property failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mwo checker: property failed");

// Next-cycle implication that is also checked while reset is high.
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mwo checker: property failed");

`endif

>>> src/mwo_pkg.sv
// ---------------------------------------------------------------------------
// mwo_pkg
// Shared widths, constants, register codes and lane/merge structs for the
// mecanum wheel odometry block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mwo_pkg;

  // Field widths
  localparam int unsigned GEAR_W     = 8;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned DEC_W      = 8;
  localparam int unsigned SEC_W      = 32;
  localparam int unsigned NSEC_W     = 30;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Serial multiplier operand, tick scale 4*g*res, and hl+hw span
  localparam int unsigned FACT_W  = 64;
  localparam int unsigned SCALE_W = GEAR_W + RES_W + 2;
  localparam int unsigned SPAN_W  = LEN_W + 1;

  // 2*pi in Q3.32 and nanoseconds per second
  localparam int unsigned TWO_PI_W = 35;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q = 35'd26986075409;
  localparam logic [NSEC_W-1:0]   NS_PER_S = 30'd1000000000;

  // Quotient bits produced by the lane divider (two guard bits over 32)
  localparam int unsigned DIV_STEPS = VEL_W + 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEAR_RATIO   = 3'd0,
    REG_TICK_RES     = 3'd1,
    REG_WHEEL_RADIUS = 3'd2,
    REG_HALF_LENGTH  = 3'd3,
    REG_HALF_WIDTH   = 3'd4,
    REG_DECIMATION   = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [GEAR_W-1:0] RST_GEAR_RATIO   = 8'd5;
  localparam logic [RES_W-1:0]  RST_TICK_RES     = 16'd42;
  localparam logic [LEN_W-1:0]  RST_WHEEL_RADIUS = 20'd4588;
  localparam logic [LEN_W-1:0]  RST_HALF_LENGTH  = 20'd13107;
  localparam logic [LEN_W-1:0]  RST_HALF_WIDTH   = 20'd11076;
  localparam logic [DEC_W-1:0]  RST_DECIMATION   = 8'd5;

  // Status of one velocity lane
  typedef struct packed {
    logic             done;
    logic [VEL_W-1:0] value;
  } lane_stat_t;

  // Request from the sequencer to the output merge stage
  typedef struct packed {
    logic              load;
    logic              time_error;
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
  } merge_req_t;

endpackage

`default_nettype wire

>>> src/mwo_if.sv
// ---------------------------------------------------------------------------
// mwo_if
// Valid/ready channel interfaces: encoder samples in, body velocities out,
// and the configuration write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mwo_in_if #(parameter int POS_WIDTH = 32);
  logic                              valid;
  logic                              ready;
  logic signed [POS_WIDTH-1:0]       pos_front_left;
  logic signed [POS_WIDTH-1:0]       pos_front_right;
  logic signed [POS_WIDTH-1:0]       pos_rear_left;
  logic signed [POS_WIDTH-1:0]       pos_rear_right;
  logic [mwo_pkg::SEC_W-1:0]         stamp_sec;
  logic [mwo_pkg::NSEC_W-1:0]        stamp_nsec;

  modport source (output valid, pos_front_left, pos_front_right, pos_rear_left,
                  pos_rear_right, stamp_sec, stamp_nsec, input ready);
  modport sink   (input valid, pos_front_left, pos_front_right, pos_rear_left,
                  pos_rear_right, stamp_sec, stamp_nsec, output ready);
endinterface

interface mwo_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwo_pkg::VEL_W-1:0]  vel_x;
  logic signed [mwo_pkg::VEL_W-1:0]  vel_y;
  logic signed [mwo_pkg::VEL_W-1:0]  yaw_rate;
  logic [mwo_pkg::SEC_W-1:0]         out_sec;
  logic [mwo_pkg::NSEC_W-1:0]        out_nsec;
  logic                              time_error;

  modport source (output valid, vel_x, vel_y, yaw_rate, out_sec, out_nsec,
                  time_error, input ready);
  modport sink   (input valid, vel_x, vel_y, yaw_rate, out_sec, out_nsec,
                  time_error, output ready);
endinterface

interface mwo_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mwo_pkg::CFG_IDX_W-1:0]     index;
  logic [mwo_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/mwo_lane.sv
// ---------------------------------------------------------------------------
// mwo_lane
// One velocity lane: serial shift-add multipliers build the exact numerator
// and denominator, then a restoring divider yields a saturated quotient.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwo_lane #(
  parameter int MAG_W     = 35,
  parameter int NUM_SHIFT = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [MAG_W-1:0]             mag,
  input  wire logic                         neg,
  input  wire logic [mwo_pkg::LEN_W-1:0]    radius,
  input  wire logic [mwo_pkg::FACT_W-1:0]   dt,
  input  wire logic [mwo_pkg::SCALE_W-1:0]  scale,
  input  wire logic [mwo_pkg::SPAN_W-1:0]   span,
  output mwo_pkg::lane_stat_t               stat
);

  localparam int NUM_W  = MAG_W + mwo_pkg::LEN_W + mwo_pkg::TWO_PI_W + mwo_pkg::NSEC_W;
  localparam int DEN_W  = mwo_pkg::SCALE_W + mwo_pkg::FACT_W + mwo_pkg::SPAN_W;
  localparam int DSR_SH = mwo_pkg::DIV_STEPS - 1 + mwo_pkg::VEL_W;
  localparam int DIV_W  = (NUM_W + NUM_SHIFT > DEN_W + DSR_SH) ?
                          NUM_W + NUM_SHIFT : DEN_W + DSR_SH;
  localparam int CNT_W  = $clog2(mwo_pkg::DIV_STEPS);
  localparam int QW     = mwo_pkg::DIV_STEPS;

  // Multiply phases
  localparam logic [1:0] PH_RADIUS = 2'd0;
  localparam logic [1:0] PH_SPAN   = 2'd1;
  localparam logic [1:0] PH_NANO   = 2'd2;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t                 state;
  logic [1:0]                  phase;
  logic [NUM_W-1:0]            nacc, nx;
  logic [mwo_pkg::FACT_W-1:0]  nm, dm;
  logic [DEN_W-1:0]            dacc, dx;
  logic [DIV_W-1:0]            rem, dsr;
  logic [QW-1:0]               q;
  logic [CNT_W-1:0]            cnt;
  logic                        num_zero, den_zero, neg_r;

  logic [mwo_pkg::VEL_W-1:0]   lim, mag_q, mag_out;

  // Sequence multiply phases and divider steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE, L_DONE: begin
          if (start) begin
            nx    <= NUM_W'(mag);
            nacc  <= '0;
            nm    <= mwo_pkg::FACT_W'(radius);
            dx    <= DEN_W'(scale);
            dacc  <= '0;
            dm    <= dt;
            neg_r <= neg;
            phase <= PH_RADIUS;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          if (nm == '0 && dm == '0) begin
            if (phase == PH_NANO) begin
              rem      <= DIV_W'(nacc) << NUM_SHIFT;
              dsr      <= DIV_W'(dacc) << DSR_SH;
              q        <= '0;
              cnt      <= '0;
              num_zero <= (nacc == '0);
              den_zero <= (dacc == '0);
              state    <= L_DIV;
            end else begin
              nx    <= nacc;
              nacc  <= '0;
              dx    <= dacc;
              dacc  <= '0;
              nm    <= (phase == PH_RADIUS) ? mwo_pkg::FACT_W'(mwo_pkg::TWO_PI_Q)
                                            : mwo_pkg::FACT_W'(mwo_pkg::NS_PER_S);
              dm    <= (phase == PH_RADIUS) ? mwo_pkg::FACT_W'(span)
                                            : mwo_pkg::FACT_W'(1);
              phase <= phase + 2'd1;
            end
          end else begin
            if (nm[0]) nacc <= nacc + nx;
            if (dm[0]) dacc <= dacc + dx;
            nx <= nx << 1;
            dx <= dx << 1;
            nm <= nm >> 1;
            dm <= dm >> 1;
          end
        end
        L_DIV: begin
          if (rem >= dsr) begin
            rem <= rem - dsr;
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            q   <= {q[QW-2:0], 1'b0};
          end
          dsr <= dsr >> 1;
          if (cnt == CNT_W'(QW - 1)) begin
            state <= L_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // Saturate toward the sign of the numerator
  always_comb begin
    lim     = neg_r ? {1'b1, {(mwo_pkg::VEL_W-1){1'b0}}}
                    : {1'b0, {(mwo_pkg::VEL_W-1){1'b1}}};
    mag_q   = (q > QW'(lim)) ? lim : q[mwo_pkg::VEL_W-1:0];
    if (num_zero) begin
      mag_out = '0;
    end else if (den_zero) begin
      mag_out = lim;
    end else begin
      mag_out = mag_q;
    end
    stat.done  = (state == L_DONE);
    stat.value = neg_r ? (~mag_out + 1'b1) : mag_out;
  end

endmodule

`default_nettype wire

>>> src/mwo_merge.sv
// ---------------------------------------------------------------------------
// mwo_merge
// Merges the three lane results and the passed-through stamp into the
// output register that drives the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwo_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  mwo_pkg::merge_req_t       req,
  input  mwo_pkg::lane_stat_t       lane_x,
  input  mwo_pkg::lane_stat_t       lane_y,
  input  mwo_pkg::lane_stat_t       lane_w,
  output logic                      free,
  mwo_out_if.source                 result
);

  logic load;

  assign free = !result.valid || result.ready;
  assign load = req.load && free;

  // Track output occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Capture the merged transaction; a timing error zeroes the velocities
  always_ff @(posedge clk) begin
    if (load) begin
      result.vel_x      <= req.time_error ? '0 : lane_x.value;
      result.vel_y      <= req.time_error ? '0 : lane_y.value;
      result.yaw_rate   <= req.time_error ? '0 : lane_w.value;
      result.out_sec    <= req.sec;
      result.out_nsec   <= req.nsec;
      result.time_error <= req.time_error;
    end
  end

endmodule

`default_nettype wire

>>> src/mecanum_wheel_odometry.sv
// ---------------------------------------------------------------------------
// mecanum_wheel_odometry
// Body velocities (vx, vy, yaw rate) from four timestamped wheel encoder
// positions by mecanum forward kinematics.
// ---------------------------------------------------------------------------
// Usage:
//   sample : valid/ready input, four signed encoder positions plus stamp.
//   result : valid/ready output, vel_x, vel_y, yaw_rate (Q16.16, saturated),
//            the stamp passed through and a time_error flag.
//   cfg    : valid/ready register writes (index, data), always ready.
// One sample in every `decimation` is used. The first used sample after
// reset only seeds the stored positions and stamp; later ones yield one
// result. Skipped and seeding samples leave the block ready for the next one.
// A result is built by the per-lane serial shift-add multipliers and the
// 34-step restoring divider; three lanes run at once. The multiply time
// grows with the bit length of the larger of dt in nanoseconds and the
// wheel radius. A non-positive dt gives a result with time_error set.
// Samples are taken one at a time; a finished result waits in the output
// register while the next sample is accepted and processed. When the
// receiver stalls, the next result holds until the register frees up.
// Reset restores register defaults and clears all sample history.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_odometry #(
  parameter int POS_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mwo_in_if.sink     sample,
  mwo_out_if.source  result,
  mwo_cfg_if.sink    cfg
);

  localparam int MAG_W = POS_WIDTH + 3;
  localparam int SEC_W = mwo_pkg::SEC_W;
  localparam int NS_W  = mwo_pkg::NSEC_W;
  localparam int DEC_W = mwo_pkg::DEC_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DT   = 6'b000010,
    S_CHK  = 6'b000100,
    S_EVAL = 6'b001000,
    S_LANE = 6'b010000,
    S_WB   = 6'b100000
  } seq_state_t;

  // Configuration registers
  logic [mwo_pkg::GEAR_W-1:0] gear_ratio;
  logic [mwo_pkg::RES_W-1:0]  tick_resolution;
  logic [mwo_pkg::LEN_W-1:0]  wheel_radius, half_length, half_width;
  logic [DEC_W-1:0]           decimation;

  // Sample history
  logic signed [POS_WIDTH-1:0] prev_fl, prev_fr, prev_rl, prev_rr;
  logic [SEC_W-1:0]            prev_sec;
  logic [NS_W-1:0]             prev_nsec;
  logic [DEC_W-1:0]            sample_phase, sample_phase_next;
  logic                        seen_first;

  // Per-item working registers
  seq_state_t                  state;
  logic [MAG_W-1:0]            mag_x, mag_y, mag_w;
  logic                        neg_x, neg_y, neg_w;
  logic signed [SEC_W:0]       dsec;
  logic signed [NS_W:0]        dnsec;
  logic signed [63:0]          dt_prod, dt;
  logic [SEC_W-1:0]            stamp_sec;
  logic [NS_W-1:0]             stamp_nsec;
  logic                        time_err;

  logic                        accept, act, lane_start, merge_free;
  logic [DEC_W-1:0]            dec_eff;
  logic [DEC_W:0]              phase_inc;
  logic signed [POS_WIDTH:0]   d_fl, d_fr, d_rl, d_rr;
  logic signed [MAG_W-1:0]     sx, sy, sw;
  logic [mwo_pkg::GEAR_W+mwo_pkg::RES_W-1:0] gear_res;
  logic [mwo_pkg::SCALE_W-1:0] scale;
  logic [mwo_pkg::SPAN_W-1:0]  span;

  mwo_pkg::lane_stat_t         stat_x, stat_y, stat_w;
  mwo_pkg::merge_req_t         mreq;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gear_ratio      <= mwo_pkg::RST_GEAR_RATIO;
      tick_resolution <= mwo_pkg::RST_TICK_RES;
      wheel_radius    <= mwo_pkg::RST_WHEEL_RADIUS;
      half_length     <= mwo_pkg::RST_HALF_LENGTH;
      half_width      <= mwo_pkg::RST_HALF_WIDTH;
      decimation      <= mwo_pkg::RST_DECIMATION;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mwo_pkg::REG_GEAR_RATIO:   gear_ratio      <= cfg.data[mwo_pkg::GEAR_W-1:0];
        mwo_pkg::REG_TICK_RES:     tick_resolution <= cfg.data[mwo_pkg::RES_W-1:0];
        mwo_pkg::REG_WHEEL_RADIUS: wheel_radius    <= cfg.data[mwo_pkg::LEN_W-1:0];
        mwo_pkg::REG_HALF_LENGTH:  half_length     <= cfg.data[mwo_pkg::LEN_W-1:0];
        mwo_pkg::REG_HALF_WIDTH:   half_width      <= cfg.data[mwo_pkg::LEN_W-1:0];
        mwo_pkg::REG_DECIMATION:   decimation      <= cfg.data[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Decimation phase and wheel sums
  always_comb begin
    dec_eff           = (decimation == '0) ? DEC_W'(1) : decimation;
    phase_inc         = {1'b0, sample_phase} + 1'b1;
    sample_phase_next = (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DEC_W-1:0];
    act               = (sample_phase == '0);
    d_fl = {sample.pos_front_left[POS_WIDTH-1],  sample.pos_front_left}
         - {prev_fl[POS_WIDTH-1], prev_fl};
    d_fr = {sample.pos_front_right[POS_WIDTH-1], sample.pos_front_right}
         - {prev_fr[POS_WIDTH-1], prev_fr};
    d_rl = {sample.pos_rear_left[POS_WIDTH-1],   sample.pos_rear_left}
         - {prev_rl[POS_WIDTH-1], prev_rl};
    d_rr = {sample.pos_rear_right[POS_WIDTH-1],  sample.pos_rear_right}
         - {prev_rr[POS_WIDTH-1], prev_rr};
    sx =  MAG_W'(d_fl) + MAG_W'(d_fr) + MAG_W'(d_rl) + MAG_W'(d_rr);
    sy = -MAG_W'(d_fl) + MAG_W'(d_fr) + MAG_W'(d_rl) - MAG_W'(d_rr);
    sw = -MAG_W'(d_fl) + MAG_W'(d_fr) - MAG_W'(d_rl) + MAG_W'(d_rr);
    gear_res = gear_ratio * tick_resolution;
    scale    = {gear_res, 2'b00};
    span     = {1'b0, half_length} + {1'b0, half_width};
  end

  assign lane_start = (state == S_EVAL) && !(dt[63] || dt == '0);

  // Sequence one sample through dt, lanes and the output merge
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_phase <= '0;
      seen_first   <= 1'b0;
      prev_fl      <= '0;
      prev_fr      <= '0;
      prev_rl      <= '0;
      prev_rr      <= '0;
      prev_sec     <= '0;
      prev_nsec    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sample_phase <= sample_phase_next;
            if (act) begin
              seen_first <= 1'b1;
              prev_fl    <= sample.pos_front_left;
              prev_fr    <= sample.pos_front_right;
              prev_rl    <= sample.pos_rear_left;
              prev_rr    <= sample.pos_rear_right;
              prev_sec   <= sample.stamp_sec;
              prev_nsec  <= sample.stamp_nsec;
              if (seen_first) begin
                mag_x      <= sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
                mag_y      <= sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
                mag_w      <= sw[MAG_W-1] ? MAG_W'(-sw) : MAG_W'(sw);
                neg_x      <= sx[MAG_W-1];
                neg_y      <= sy[MAG_W-1];
                neg_w      <= sw[MAG_W-1];
                dsec       <= $signed({1'b0, sample.stamp_sec}) - $signed({1'b0, prev_sec});
                dnsec      <= $signed({1'b0, sample.stamp_nsec}) - $signed({1'b0, prev_nsec});
                stamp_sec  <= sample.stamp_sec;
                stamp_nsec <= sample.stamp_nsec;
                state      <= S_DT;
              end
            end
          end
        end
        S_DT: begin
          dt_prod <= {{(63 - SEC_W){dsec[SEC_W]}}, dsec} * 64'sd1000000000;
          state   <= S_CHK;
        end
        S_CHK: begin
          dt    <= dt_prod + {{(63 - NS_W){dnsec[NS_W]}}, dnsec};
          state <= S_EVAL;
        end
        S_EVAL: begin
          time_err <= !lane_start;
          state    <= lane_start ? S_LANE : S_WB;
        end
        S_LANE: begin
          if (stat_x.done && stat_y.done && stat_w.done) state <= S_WB;
        end
        S_WB: begin
          if (merge_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Velocity lanes
  mwo_lane #(.MAG_W(MAG_W), .NUM_SHIFT(0)) u_lane_x (
    .clk, .rst, .start(lane_start), .mag(mag_x), .neg(neg_x), .radius(wheel_radius),
    .dt(dt), .scale(scale), .span(mwo_pkg::SPAN_W'(1)), .stat(stat_x)
  );

  mwo_lane #(.MAG_W(MAG_W), .NUM_SHIFT(0)) u_lane_y (
    .clk, .rst, .start(lane_start), .mag(mag_y), .neg(neg_y), .radius(wheel_radius),
    .dt(dt), .scale(scale), .span(mwo_pkg::SPAN_W'(1)), .stat(stat_y)
  );

  mwo_lane #(.MAG_W(MAG_W), .NUM_SHIFT(FRAC_BITS)) u_lane_w (
    .clk, .rst, .start(lane_start), .mag(mag_w), .neg(neg_w), .radius(wheel_radius),
    .dt(dt), .scale(scale), .span(span), .stat(stat_w)
  );

  // Output merge
  always_comb begin
    mreq.load       = (state == S_WB);
    mreq.time_error = time_err;
    mreq.sec        = stamp_sec;
    mreq.nsec       = stamp_nsec;
  end

  mwo_merge u_merge (
    .clk, .rst, .req(mreq), .lane_x(stat_x), .lane_y(stat_y), .lane_w(stat_w),
    .free(merge_free), .result(result)
  );

endmodule

`default_nettype wire

>>> src/mwo_checker.sv
// ---------------------------------------------------------------------------
// mwo_checker
// Port-level checks on the odometry block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwo_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [mwo_pkg::VEL_W-1:0] vel_x,
  input wire logic signed [mwo_pkg::VEL_W-1:0] vel_y,
  input wire logic signed [mwo_pkg::VEL_W-1:0] yaw_rate,
  input wire logic [mwo_pkg::SEC_W-1:0]        out_sec,
  input wire logic                             time_error
);

  // Hold a stalled transaction
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(vel_x) && $stable(yaw_rate) && $stable(out_sec))

  // Timing errors carry zero velocities
  `ASSERT_IMPLIES(a_err_zero, out_valid && time_error, vel_x == 0 && vel_y == 0 && yaw_rate == 0)

  // A result never appears right after a sample is taken
  `ASSERT_IMPLIES(a_min_latency, $rose(out_valid), !$past(in_valid && in_ready))

  // Reset empties the output register
  `ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)

endmodule

bind mecanum_wheel_odometry mwo_checker u_mwo_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample.valid),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .vel_x      (result.vel_x),
  .vel_y      (result.vel_y),
  .yaw_rate   (result.yaw_rate),
  .out_sec    (result.out_sec),
  .time_error (result.time_error)
);

`default_nettype wire

>>> sim/odometry_checker.sv
// ---------------------------------------------------------------------------
// odometry_checker
// Watches the sample, result and configuration channels of the mecanum
// odometry block. It predicts each result with exact wide arithmetic and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module odometry_checker (
  input  logic clk,
  input  logic rst,
  mwo_in_if    sample,
  mwo_out_if   result,
  mwo_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  localparam int FRAC_BITS_SHIFT = 16;

  typedef struct {
    logic [mwo_pkg::VEL_W-1:0]  vel_x;
    logic [mwo_pkg::VEL_W-1:0]  vel_y;
    logic [mwo_pkg::VEL_W-1:0]  yaw_rate;
    logic [mwo_pkg::SEC_W-1:0]  sec;
    logic [mwo_pkg::NSEC_W-1:0] nsec;
    logic                       time_error;
  } motion_t;

  motion_t expected_motion[$];

  // Register copies
  logic [mwo_pkg::GEAR_W-1:0] gear;
  logic [mwo_pkg::RES_W-1:0]  res;
  logic [mwo_pkg::LEN_W-1:0]  radius, half_len, half_wid;
  logic [mwo_pkg::DEC_W-1:0]  decim;

  // Sample history
  longint                     last_pos[4];
  logic [mwo_pkg::SEC_W-1:0]  last_sec;
  logic [mwo_pkg::NSEC_W-1:0] last_nsec;
  int                         phase;
  bit                         seeded;

  // Truncated quotient, saturated to signed 32 bits toward the given sign
  function automatic logic [31:0] sat_quotient(logic [255:0] n, logic [255:0] d, bit neg);
    logic [31:0]  lim;
    logic [31:0]  mag;
    logic [255:0] q;
    lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (n == 0) return 32'd0;
    if (d == 0) begin
      mag = lim;
    end else begin
      q = n / d;
      mag = (q > {224'd0, lim}) ? lim : q[31:0];
    end
    return neg ? (32'd0 - mag) : mag;
  endfunction

  function automatic logic [255:0] wheel_numerator(longint s,
                                                   logic [mwo_pkg::LEN_W-1:0] r);
    logic [255:0] n;
    n = (s < 0) ? 256'(-s) : 256'(s);
    n = n * r;
    n = n * mwo_pkg::TWO_PI_Q;
    n = n * mwo_pkg::NS_PER_S;
    return n;
  endfunction

  // Work out what one accepted sample produces
  task automatic odom_predict();
    longint       pos[4];
    longint       d[4];
    longint       dt, sx, sy, sw;
    int           dec_eff;
    bit           act;
    motion_t      m;
    logic [255:0] den, den_yaw;
    dec_eff = (decim == 0) ? 1 : int'(decim);
    act = (phase == 0);
    phase = (phase + 1 >= dec_eff) ? 0 : phase + 1;
    if (!act) return;
    pos[0] = longint'(signed'(sample.pos_front_left));
    pos[1] = longint'(signed'(sample.pos_front_right));
    pos[2] = longint'(signed'(sample.pos_rear_left));
    pos[3] = longint'(signed'(sample.pos_rear_right));
    if (!seeded) begin
      seeded = 1;
      for (int i = 0; i < 4; i++) last_pos[i] = pos[i];
      last_sec = sample.stamp_sec;
      last_nsec = sample.stamp_nsec;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      d[i] = pos[i] - last_pos[i];
      last_pos[i] = pos[i];
    end
    dt = (longint'(sample.stamp_sec) - longint'(last_sec)) * 64'd1000000000
       + (longint'(sample.stamp_nsec) - longint'(last_nsec));
    last_sec = sample.stamp_sec;
    last_nsec = sample.stamp_nsec;
    m.sec = sample.stamp_sec;
    m.nsec = sample.stamp_nsec;
    if (dt <= 0) begin
      m.vel_x = '0;
      m.vel_y = '0;
      m.yaw_rate = '0;
      m.time_error = 1'b1;
    end else begin
      m.time_error = 1'b0;
      sx = d[0] + d[1] + d[2] + d[3];
      sy = -d[0] + d[1] + d[2] - d[3];
      sw = -d[0] + d[1] - d[2] + d[3];
      den = 256'(gear);
      den = den * res * 4;
      den = den * 256'(dt);
      den = den << 32;
      den_yaw = den * (256'(half_len) + half_wid);
      m.vel_x = sat_quotient(wheel_numerator(sx, radius), den, sx < 0);
      m.vel_y = sat_quotient(wheel_numerator(sy, radius), den, sy < 0);
      m.yaw_rate = sat_quotient(wheel_numerator(sw, radius) << FRAC_BITS_SHIFT, den_yaw,
                                sw < 0);
    end
    expected_motion.push_back(m);
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    motion_t m;
    if (expected_motion.size() == 0) begin
      $error("result transaction with nothing expected");
      errors++;
      return;
    end
    m = expected_motion.pop_front();
    compare_field("vel_x", m.vel_x, result.vel_x);
    compare_field("vel_y", m.vel_y, result.vel_y);
    compare_field("yaw_rate", m.yaw_rate, result.yaw_rate);
    compare_field("out_sec", m.sec, result.out_sec);
    compare_field("out_nsec", 32'(m.nsec), 32'(result.out_nsec));
    compare_field("time_error", 32'(m.time_error), 32'(result.time_error));
  endtask

  initial errors = 0;

  // Track registers, predict, compare
  always @(posedge clk) begin
    if (rst) begin
      gear = mwo_pkg::RST_GEAR_RATIO;
      res = mwo_pkg::RST_TICK_RES;
      radius = mwo_pkg::RST_WHEEL_RADIUS;
      half_len = mwo_pkg::RST_HALF_LENGTH;
      half_wid = mwo_pkg::RST_HALF_WIDTH;
      decim = mwo_pkg::RST_DECIMATION;
      for (int i = 0; i < 4; i++) last_pos[i] = 0;
      last_sec = '0;
      last_nsec = '0;
      phase = 0;
      seeded = 0;
      expected_motion.delete();
    end else begin
      if (result.valid && result.ready) check_result();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mwo_pkg::REG_GEAR_RATIO:   gear = cfg.data[mwo_pkg::GEAR_W-1:0];
          mwo_pkg::REG_TICK_RES:     res = cfg.data[mwo_pkg::RES_W-1:0];
          mwo_pkg::REG_WHEEL_RADIUS: radius = cfg.data[mwo_pkg::LEN_W-1:0];
          mwo_pkg::REG_HALF_LENGTH:  half_len = cfg.data[mwo_pkg::LEN_W-1:0];
          mwo_pkg::REG_HALF_WIDTH:   half_wid = cfg.data[mwo_pkg::LEN_W-1:0];
          mwo_pkg::REG_DECIMATION:   decim = cfg.data[mwo_pkg::DEC_W-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) odom_predict();
    end
    pending <= expected_motion.size();
  end

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives encoder samples and register writes into the mecanum odometry
// block under random back-pressure and idle gaps; the checker beside it
// predicts every result and reports mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  bit   calm;

  mwo_in_if #(.POS_WIDTH(32)) smp();
  mwo_out_if                  res();
  mwo_cfg_if                  cfgc();

  mecanum_wheel_odometry DUT (
    .clk(clk), .rst(rst), .sample(smp), .result(res), .cfg(cfgc)
  );

  odometry_checker checker_0 (
    .clk(clk), .rst(rst), .sample(smp), .result(res), .cfg(cfgc),
    .errors(errors), .pending(pending)
  );

  // Current motion of the simulated robot
  logic [31:0] cur_pos[4];
  logic [31:0] cur_sec;
  logic [29:0] cur_nsec;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    res.ready <= calm || ($urandom_range(99) >= 37);
  end

  // Send one sample transaction; valid stays high afterwards
  task automatic send_sample(logic [31:0] fl, logic [31:0] fr, logic [31:0] rl,
                             logic [31:0] rr, logic [31:0] sec, logic [29:0] nsec);
    if (!calm && $urandom_range(99) < 37) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.pos_front_left <= fl;
    smp.pos_front_right <= fr;
    smp.pos_rear_left <= rl;
    smp.pos_rear_right <= rr;
    smp.stamp_sec <= sec;
    smp.stamp_nsec <= nsec;
    do @(posedge clk); while (!smp.ready);
  endtask

  // Hold the sender until every result is in, then let the block settle
  task automatic drain();
    smp.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(mwo_pkg::cfg_reg_t idx, logic [31:0] value, int w);
    logic [31:0] junk;
    junk = $urandom;
    cfgc.valid <= 1'b1;
    cfgc.index <= idx;
    cfgc.data <= (junk << w) | value;
    do @(posedge clk); while (!cfgc.ready);
  endtask

  task automatic set_config(int g, int r, int rad, int hl, int hw, int dec);
    drain();
    write_reg(mwo_pkg::REG_GEAR_RATIO, g, mwo_pkg::GEAR_W);
    write_reg(mwo_pkg::REG_TICK_RES, r, mwo_pkg::RES_W);
    write_reg(mwo_pkg::REG_WHEEL_RADIUS, rad, mwo_pkg::LEN_W);
    write_reg(mwo_pkg::REG_HALF_LENGTH, hl, mwo_pkg::LEN_W);
    write_reg(mwo_pkg::REG_HALF_WIDTH, hw, mwo_pkg::LEN_W);
    write_reg(mwo_pkg::REG_DECIMATION, dec, mwo_pkg::DEC_W);
    cfgc.valid <= 1'b0;
  endtask

  // Advance the stamp by dt nanoseconds, carrying into seconds
  task automatic advance(longint dt);
    longint ns;
    ns = longint'(cur_nsec) + dt;
    while (ns >= 1000000000) begin
      ns -= 1000000000;
      cur_sec++;
    end
    while (ns < 0) begin
      ns += 1000000000;
      cur_sec--;
    end
    cur_nsec = ns[29:0];
  endtask

  task automatic send_current();
    send_sample(cur_pos[0], cur_pos[1], cur_pos[2], cur_pos[3], cur_sec, cur_nsec);
  endtask

  task automatic move(int a, int b, int c, int d, longint dt);
    cur_pos[0] += a;
    cur_pos[1] += b;
    cur_pos[2] += c;
    cur_pos[3] += d;
    advance(dt);
    send_current();
  endtask

  // One random sample: mostly smooth motion, some noise and bad stamps
  task automatic random_sample();
    int sel;
    int span;
    sel = $urandom_range(99);
    span = ($urandom_range(9) < 7) ? 2000 : 2000000;
    for (int i = 0; i < 4; i++) begin
      if (sel < 6) cur_pos[i] = $urandom;
      else cur_pos[i] += $urandom_range(2 * span) - span;
    end
    sel = $urandom_range(99);
    if (sel < 5) ;
    else if (sel < 10) advance(-longint'($urandom_range(1, 3000000000)));
    else if (sel < 13) cur_nsec = 30'($urandom);
    else if (sel < 16) cur_sec = $urandom;
    else if (sel < 20) advance($urandom_range(1, 1000));
    else advance($urandom_range(1000, 50000000));
    send_current();
  endtask

  task automatic random_config();
    int g, r, rad, dec;
    g = ($urandom_range(9) == 0) ? 255 : $urandom_range(1, 255);
    r = ($urandom_range(9) == 0) ? 65535 : $urandom_range(1, 65535);
    rad = $urandom_range(1, 1048575) >> $urandom_range(0, 12);
    dec = $urandom_range(1, 4);
    set_config(g, r, rad, $urandom_range(0, 1048575) >> $urandom_range(0, 8),
               $urandom_range(0, 1048575) >> $urandom_range(0, 8), dec);
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    smp.valid = 1'b0;
    smp.pos_front_left = '0;
    smp.pos_front_right = '0;
    smp.pos_rear_left = '0;
    smp.pos_rear_right = '0;
    smp.stamp_sec = '0;
    smp.stamp_nsec = '0;
    res.ready = 1'b0;
    cfgc.valid = 1'b0;
    cfgc.index = mwo_pkg::REG_GEAR_RATIO;
    cfgc.data = '0;
    for (int i = 0; i < 4; i++) cur_pos[i] = '0;
    cur_sec = 32'd10;
    cur_nsec = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults, decimation of five
    for (int i = 0; i < 10; i++) move(37, -12, 5, 90, 20000000);

    // Directed: one sample per step
    set_config(5, 42, 4588, 13107, 11076, 1);
    move(100, 100, 100, 100, 10000000);
    move(-100, 100, 100, -100, 10000000);
    move(-100, 100, -100, 100, 10000000);
    cur_pos[0] = 32'h7fff_ffff; cur_pos[1] = 32'h7fff_ffff;
    cur_pos[2] = 32'h7fff_ffff; cur_pos[3] = 32'h7fff_ffff;
    advance(1);
    send_current();
    cur_pos[0] = 32'h8000_0000; cur_pos[1] = 32'h8000_0000;
    cur_pos[2] = 32'h8000_0000; cur_pos[3] = 32'h8000_0000;
    advance(1);
    send_current();
    // zero and negative elapsed time
    move(5, 5, 5, 5, 0);
    move(5, 5, 5, 5, -1000);
    // nanoseconds beyond one second, used raw
    cur_nsec = 30'h3fff_ffff;
    send_current();
    move(1, 2, 3, 4, 1);
    cur_nsec = 30'd999999999;
    cur_sec = 32'hffff_ffff;
    send_current();
    move(0, 0, 0, 0, 5000);
    cur_sec = 32'd0;
    cur_nsec = 30'd0;
    send_current();

    // Extreme settings, zero divisors and zero decimation among them
    set_config(255, 65535, 1048575, 1048575, 1048575, 1);
    for (int i = 0; i < 40; i++) random_sample();
    set_config(1, 1, 1, 0, 0, 2);
    for (int i = 0; i < 40; i++) random_sample();
    set_config(0, 0, 1048575, 0, 0, 0);
    for (int i = 0; i < 40; i++) random_sample();
    set_config(3, 100, 30000, 20000, 15000, 255);
    for (int i = 0; i < 300; i++) random_sample();
    // lowering decimation below the running phase
    set_config(3, 100, 30000, 20000, 15000, 1);
    for (int i = 0; i < 40; i++) random_sample();

    // Random settings, one stretch without any idling
    for (int p = 0; p < 10; p++) begin
      random_config();
      calm = (p == 4);
      for (int i = 0; i < 70; i++) random_sample();
    end
    calm = 1'b0;

    smp.valid <= 1'b0;
    for (int c = 0; c < 200000 && pending != 0; c++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/mwo_pkg.sv
src/mwo_if.sv
src/mwo_lane.sv
src/mwo_merge.sv
src/mecanum_wheel_odometry.sv
src/mwo_checker.sv
sim/odometry_checker.sv
sim/testbench.sv
